// ===== src/etmm_pkg.sv =====
// ----------------------------------------------------------------------------
// etmm_pkg
// Constants, payload types and helpers of the model matrix core.
// ----------------------------------------------------------------------------
package etmm_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned AngW = 36;

  localparam logic signed [AngW-1:0] TwoPiQ28  = 36'sd1686629713;
  localparam logic signed [AngW-1:0] PiQ28     = 36'sd843314857;
  localparam logic signed [AngW-1:0] HalfPiQ28 = 36'sd421657428;
  localparam logic signed [33:0]     GainQ30   = 34'sd652032874;

  typedef logic signed [33:0] trig_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] c0_r0;
    logic signed [31:0] c0_r1;
    logic signed [31:0] c0_r2;
    logic signed [31:0] c1_r0;
    logic signed [31:0] c1_r1;
    logic signed [31:0] c1_r2;
    logic signed [31:0] c2_r0;
    logic signed [31:0] c2_r1;
    logic signed [31:0] c2_r2;
    logic signed [31:0] tr_x;
    logic signed [31:0] tr_y;
    logic signed [31:0] tr_z;
  } out_item_t;

  function automatic logic signed [AngW-1:0] atan_q28(input logic [4:0] i);
    case (i)
      5'd0:  atan_q28 = 36'sd210828714;
      5'd1:  atan_q28 = 36'sd124459457;
      5'd2:  atan_q28 = 36'sd65760959;
      5'd3:  atan_q28 = 36'sd33381290;
      5'd4:  atan_q28 = 36'sd16755422;
      5'd5:  atan_q28 = 36'sd8385879;
      5'd6:  atan_q28 = 36'sd4193963;
      5'd7:  atan_q28 = 36'sd2097109;
      5'd8:  atan_q28 = 36'sd1048571;
      5'd9:  atan_q28 = 36'sd524287;
      default: atan_q28 = 36'sd1 <<< (5'd28 - i);
    endcase
  endfunction

  // round(a*b / 2^30)
  function automatic trig_t mul30(input trig_t a, input trig_t b);
    logic signed [67:0] p;
    p = a * b + (68'sd1 <<< 29);
    mul30 = trig_t'(p >>> 30);
  endfunction

  function automatic logic signed [31:0] scale_sat(input logic signed [35:0] e,
                                                   input logic signed [15:0] sc);
    logic signed [51:0] p;
    logic signed [51:0] v;
    p = e * sc + (52'sd1 <<< 21);
    v = p >>> 22;
    if (v > 52'sd2147483647) scale_sat = 32'sh7fffffff;
    else if (v < -52'sd2147483648) scale_sat = 32'sh80000000;
    else scale_sat = v[31:0];
  endfunction

endpackage

// ===== src/etmm_stream_if.sv =====
// ----------------------------------------------------------------------------
// etmm_stream_if
// Valid/ready channel carrying one payload of the given type.
// ----------------------------------------------------------------------------
interface etmm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/euler_trs_model_matrix_core.sv =====
// ----------------------------------------------------------------------------
// euler_trs_model_matrix_core
// Y-X-Z Euler TRS local model matrix in Q16.16 from a pipelined CORDIC.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the output is not stalled; 24
// CORDIC stages, one micro-rotation per stage per angle, set most of the depth.
// Backpressure stalls the whole pipeline in place.
// Reset clears all valid bits; payload registers are not reset.
module euler_trs_model_matrix_core (
  input logic clk_i,
  input logic rst_ni,
  etmm_stream_if.sink   in_if,
  etmm_stream_if.source out_if
);
  import etmm_pkg::*;

  localparam int unsigned Depth = CordicSteps + 7;

  logic adv;
  logic [Depth-1:0] vld_q;

  assign adv         = !vld_q[Depth-1] || out_if.ready;
  assign in_if.ready = adv;
  assign out_if.valid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_if.valid};
    end
  end

  // stage 0: modulo reduction (2^16*a, mod by compare over known range)
  in_item_t item_q [Depth-1];
  logic signed [AngW-1:0] r0_q [3];

  function automatic logic signed [AngW-1:0] reduce(input logic signed [15:0] a);
    logic signed [AngW-1:0] v;
    v = AngW'(a) <<< 16;
    // |v| <= 2^31 < 3*pi, so one correction of 2*pi lands in [-pi, pi)
    if (v >= PiQ28) reduce = v - TwoPiQ28;
    else if (v < -PiQ28) reduce = v + TwoPiQ28;
    else reduce = v;
  endfunction

  // stage 1: quadrant fold
  logic signed [AngW-1:0] z_q [CordicSteps+1][3];
  trig_t x_q [CordicSteps+1][3];
  trig_t y_q [CordicSteps+1][3];
  logic [2:0] neg_q [CordicSteps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_q[0] <= in_if.data;
      r0_q[0] <= reduce(in_if.data.angle_y);
      r0_q[1] <= reduce(in_if.data.angle_x);
      r0_q[2] <= reduce(in_if.data.angle_z);
      for (int k = 1; k < Depth-1; k++) item_q[k] <= item_q[k-1];
      for (int a = 0; a < 3; a++) begin
        x_q[0][a] <= GainQ30;
        y_q[0][a] <= '0;
        if (r0_q[a] > HalfPiQ28) begin
          z_q[0][a] <= r0_q[a] - PiQ28;
          neg_q[0][a] <= 1'b1;
        end else if (r0_q[a] < -HalfPiQ28) begin
          z_q[0][a] <= r0_q[a] + PiQ28;
          neg_q[0][a] <= 1'b1;
        end else begin
          z_q[0][a] <= r0_q[a];
          neg_q[0][a] <= 1'b0;
        end
      end
      for (int i = 0; i < CordicSteps; i++) begin
        neg_q[i+1] <= neg_q[i];
        for (int a = 0; a < 3; a++) begin
          if (z_q[i][a] >= 0) begin
            x_q[i+1][a] <= x_q[i][a] - (y_q[i][a] >>> i);
            y_q[i+1][a] <= y_q[i][a] + (x_q[i][a] >>> i);
            z_q[i+1][a] <= z_q[i][a] - atan_q28(5'(i));
          end else begin
            x_q[i+1][a] <= x_q[i][a] + (y_q[i][a] >>> i);
            y_q[i+1][a] <= y_q[i][a] - (x_q[i][a] >>> i);
            z_q[i+1][a] <= z_q[i][a] + atan_q28(5'(i));
          end
        end
      end
    end
  end

  // stage CordicSteps+2: sign fix; then products, sums, scale, saturate
  trig_t s_q [3], c_q [3];
  trig_t pq_q [2];
  trig_t s1b_q, c1b_q, s2b_q, c2b_q, s3b_q, c3b_q;
  trig_t m_q [11];
  trig_t s2d_q, m8b_q;
  logic signed [35:0] e_q [9];
  out_item_t res_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        s_q[a] <= neg_q[CordicSteps][a] ? -y_q[CordicSteps][a] : y_q[CordicSteps][a];
        c_q[a] <= neg_q[CordicSteps][a] ? -x_q[CordicSteps][a] : x_q[CordicSteps][a];
      end
      pq_q[0] <= mul30(s_q[0], s_q[1]);
      pq_q[1] <= mul30(c_q[0], s_q[1]);
      s1b_q <= s_q[0]; c1b_q <= c_q[0];
      s2b_q <= s_q[1]; c2b_q <= c_q[1];
      s3b_q <= s_q[2]; c3b_q <= c_q[2];
      m_q[0]  <= mul30(c1b_q, c3b_q);
      m_q[1]  <= mul30(pq_q[0], s3b_q);
      m_q[2]  <= mul30(c2b_q, s3b_q);
      m_q[3]  <= mul30(pq_q[1], s3b_q);
      m_q[4]  <= mul30(c3b_q, s1b_q);
      m_q[5]  <= mul30(pq_q[0], c3b_q);
      m_q[6]  <= mul30(c1b_q, s3b_q);
      m_q[7]  <= mul30(c2b_q, c3b_q);
      m_q[8]  <= mul30(pq_q[1], c3b_q);
      m_q[9]  <= mul30(s1b_q, s3b_q);
      m_q[10] <= mul30(c2b_q, s1b_q);
      e_q[0] <= 36'(m_q[0]) + 36'(m_q[1]);
      e_q[1] <= 36'(m_q[2]);
      e_q[2] <= 36'(m_q[3]) - 36'(m_q[4]);
      e_q[3] <= 36'(m_q[5]) - 36'(m_q[6]);
      e_q[4] <= 36'(m_q[7]);
      e_q[5] <= 36'(m_q[8]) + 36'(m_q[9]);
      e_q[6] <= 36'(m_q[10]);
      e_q[7] <= -36'(s2d_q);
      e_q[8] <= 36'(m8b_q);
      res_q.c0_r0 <= scale_sat(e_q[0], item_q[Depth-2].scale_x);
      res_q.c0_r1 <= scale_sat(e_q[1], item_q[Depth-2].scale_x);
      res_q.c0_r2 <= scale_sat(e_q[2], item_q[Depth-2].scale_x);
      res_q.c1_r0 <= scale_sat(e_q[3], item_q[Depth-2].scale_y);
      res_q.c1_r1 <= scale_sat(e_q[4], item_q[Depth-2].scale_y);
      res_q.c1_r2 <= scale_sat(e_q[5], item_q[Depth-2].scale_y);
      res_q.c2_r0 <= scale_sat(e_q[6], item_q[Depth-2].scale_z);
      res_q.c2_r1 <= scale_sat(e_q[7], item_q[Depth-2].scale_z);
      res_q.c2_r2 <= scale_sat(e_q[8], item_q[Depth-2].scale_z);
      res_q.tr_x <= item_q[Depth-2].pos_x;
      res_q.tr_y <= item_q[Depth-2].pos_y;
      res_q.tr_z <= item_q[Depth-2].pos_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2d_q <= s2b_q;
      m8b_q <= mul30(c1b_q, c2b_q);
    end
  end

  assign out_if.data = res_q;

  // sign fix at index CordicSteps+2; pq +3; products +4; sums +5; scale +6
  // -> Depth-1 = CordicSteps+6, so data aligns with vld_q[Depth-1]

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("input stalled while pipeline drains");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> vld_q[0])
    else $error("accepted transaction lost");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives position, Euler angles and scale into the model matrix core under
// random idling and backpressure, predicts each matrix with a CORDIC
// computation of its own and compares each returned transaction with its
// prediction as a whole.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import etmm_pkg::*;

  localparam int unsigned PipeDepth = 31;
  localparam int unsigned StallLimit = 20000;

  typedef enum int {
    IdleNone,
    IdleSend,
    IdleRecv,
    IdleBoth
  } idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  etmm_stream_if #(.T(in_item_t))  in_if ();
  etmm_stream_if #(.T(out_item_t)) out_if ();

  euler_trs_model_matrix_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  in_item_t   pending_q[$];
  out_item_t  matrix_q[$];
  idle_mode_e idle_mode = IdleNone;
  bit         hold_send = 1'b0;
  int         mismatches = 0;
  int         n_sent = 0;
  int         n_recv = 0;
  int         quiet_cycles = 0;

  const longint unsigned AtanTab[24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
  };

  function automatic longint round30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void sin_cos_q30(logic signed [15:0] ang, output longint s,
                                      output longint c);
    longint r, x, y, nx;
    bit     flip;
    r = (longint'(ang) * 65536) % 1686629713;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (r < 0) r += 1686629713;
    if (r >= 843314857) r -= 1686629713;
    if (r > 421657428) begin
      r -= 843314857;
      flip = 1'b1;
    end else if (r < -421657428) begin
      r += 843314857;
      flip = 1'b1;
    end
    for (int i = 0; i < 24; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        r -= longint'(AtanTab[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        r += longint'(AtanTab[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [31:0] to_q16(longint e, logic signed [15:0] sc);
    longint v;
    v = (e * longint'(sc) + (64'sd1 <<< 21)) >>> 22;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic out_item_t model_matrix(in_item_t t);
    out_item_t m;
    longint s1, c1, s2, c2, s3, c3, p, q;
    sin_cos_q30(t.angle_y, s1, c1);
    sin_cos_q30(t.angle_x, s2, c2);
    sin_cos_q30(t.angle_z, s3, c3);
    p = round30(s1, s2);
    q = round30(c1, s2);
    m.c0_r0 = to_q16(round30(c1, c3) + round30(p, s3), t.scale_x);
    m.c0_r1 = to_q16(round30(c2, s3), t.scale_x);
    m.c0_r2 = to_q16(round30(q, s3) - round30(c3, s1), t.scale_x);
    m.c1_r0 = to_q16(round30(p, c3) - round30(c1, s3), t.scale_y);
    m.c1_r1 = to_q16(round30(c2, c3), t.scale_y);
    m.c1_r2 = to_q16(round30(q, c3) + round30(s1, s3), t.scale_y);
    m.c2_r0 = to_q16(round30(c2, s1), t.scale_z);
    m.c2_r1 = to_q16(-s2, t.scale_z);
    m.c2_r2 = to_q16(round30(c1, c2), t.scale_z);
    m.tr_x = t.pos_x;
    m.tr_y = t.pos_y;
    m.tr_z = t.pos_z;
    return m;
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(25736)) - 12868);
      2: return 16'($signed($urandom_range(64)) - 32) + 16'(6434 * $urandom_range(7));
      default: return 16'({$urandom_range(3), 12'h000}) ^ 16'($urandom_range(3));
    endcase
  endfunction

  function automatic logic [15:0] rand_scale();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'h0100;
      2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(2048)) - 1024);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t t;
    t.pos_x = $urandom;
    t.pos_y = $urandom;
    t.pos_z = $urandom;
    t.angle_x = rand_angle();
    t.angle_y = rand_angle();
    t.angle_z = rand_angle();
    t.scale_x = rand_scale();
    t.scale_y = rand_scale();
    t.scale_z = rand_scale();
    return t;
  endfunction

  function automatic in_item_t make_item(logic [15:0] ax, logic [15:0] ay,
                                         logic [15:0] az, logic [15:0] sc,
                                         logic [31:0] pos);
    in_item_t t;
    t.pos_x = pos;
    t.pos_y = ~pos;
    t.pos_z = pos ^ 32'h5a5a_a5a5;
    t.angle_x = ax;
    t.angle_y = ay;
    t.angle_z = az;
    t.scale_x = sc;
    t.scale_y = sc;
    t.scale_z = -sc;
    return t;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        matrix_q = {matrix_q, model_matrix(in_if.data)};
        n_sent++;
      end
      if ((!in_if.valid || in_if.ready) ) begin
        if (pending_q.size() != 0 && !hold_send &&
            !((idle_mode == IdleSend || idle_mode == IdleBoth) &&
              roll(idle_mode == IdleSend ? 66 : 13))) begin
          in_if.valid <= 1'b1;
          in_if.data  <= pending_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e, a;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        a = out_if.data;
        n_recv++;
        if (matrix_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %h", a);
        end else begin
          e = matrix_q.pop_front();
          if (e !== a) begin
            mismatches++;
            if (mismatches <= 10)
              $display("matrix mismatch\n  exp %h\n  got %h", e, a);
          end
        end
      end
      out_if.ready <= !((idle_mode == IdleRecv || idle_mode == IdleBoth) &&
                        roll(idle_mode == IdleRecv ? 66 : 13));
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic drain();
    while (pending_q.size() != 0 || in_if.valid || matrix_q.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] ang_edges[8];
    ang_edges = '{16'h0000, 16'h7fff, 16'h8000, 16'd6434, 16'd6433, -16'sd6434,
                  16'd12868, 16'd25736};
    for (int i = 0; i < 8; i++)
      pending_q = {pending_q, make_item(ang_edges[i], ang_edges[7 - i],
                                        ang_edges[(i + 3) % 8], 16'h0100, 32'h0000_0000)};
    pending_q = {pending_q, make_item(16'h0000, 16'h0000, 16'h0000, 16'h7fff, 32'h7fff_ffff)};
    pending_q = {pending_q, make_item(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 32'h8000_0000)};
    pending_q = {pending_q, make_item(16'h1000, 16'h2000, 16'h3000, 16'h0000, 32'hffff_ffff)};
    pending_q = {pending_q, make_item(16'hf000, 16'he000, 16'hd000, 16'hff00, 32'h0001_0000)};
    pending_q = {pending_q, make_item(16'h0c91, 16'h1922, 16'h3244, 16'hffff, 32'h1234_5678)};
    pending_q = {pending_q, make_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'haaaa_5555)};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = idle_mode_e'(ph % 4);
      repeat (110) pending_q = {pending_q, rand_item()};
      if (ph == 4) begin
        repeat (40) @(posedge clk_i);
        hold_send = 1'b1;
        while (matrix_q.size() != 0 || in_if.valid) @(posedge clk_i);
        hold_send = 1'b0;
      end
      drain();
    end
    repeat (PipeDepth * 4) @(posedge clk_i);
    $display("sent %0d transforms, received %0d matrices over four idling modes",
             n_sent, n_recv);
    if (mismatches == 0 && matrix_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
